>>> sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared sizes, types and handoff structs of the 3-D tour cost engine.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Capacity and coordinate precision.
  localparam int MAX_CITIES = 16;
  localparam int COORD_BITS = 32;

  // Fixed widths of the channel fields.
  localparam int IN_W   = 32;
  localparam int TOUR_W = 40;

  // Derived sizes.
  localparam int CITY_W  = $clog2(MAX_CITIES);
  localparam int CNT_W   = $clog2(MAX_CITIES + 1);
  localparam int MASK_W  = MAX_CITIES - 1;
  localparam int EDGE_W  = COORD_BITS + 3;
  localparam int EDGE_AW = 2 * CITY_W;
  localparam int DP_AW   = MASK_W + CITY_W;

  localparam int CITY_DEPTH = 1 << CITY_W;
  localparam int EDGE_DEPTH = 1 << EDGE_AW;
  localparam int DP_DEPTH   = 1 << DP_AW;

  typedef logic signed [IN_W-1:0]       in_coord_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic [EDGE_W-1:0]            edge_t;
  typedef logic [TOUR_W-1:0]            tour_t;
  typedef logic [CITY_W-1:0]            city_idx_t;
  typedef logic [CNT_W-1:0]             city_cnt_t;
  typedef logic [MASK_W-1:0]            mask_t;
  typedef logic [EDGE_AW-1:0]           edge_addr_t;
  typedef logic [DP_AW-1:0]             dp_addr_t;

  // Start command for the edge builder and the DP core.
  typedef struct packed {
    logic      start;
    city_cnt_t n;
  } run_ctl_t;

  // Completion report of the DP core.
  typedef struct packed {
    logic  done;
    tour_t cost;
  } dp_stat_t;

endpackage

>>> sv/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_city_if / tsp_result_if
// Valid/ready channels for city beats and tour result beats.
// ----------------------------------------------------------------------------
interface tsp_city_if;
  import tsp_pkg::*;

  logic      valid;
  logic      ready;
  in_coord_t coord_x;
  in_coord_t coord_y;
  in_coord_t coord_z;
  logic      last_city;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output last_city, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input last_city, output ready);
endinterface

interface tsp_result_if;
  import tsp_pkg::*;

  logic  valid;
  logic  ready;
  tour_t tour_cost;
  logic  too_many;

  modport source (output valid, output tour_cost, output too_many, input ready);
  modport sink   (input valid, input tour_cost, input too_many, output ready);
endinterface

>>> sv/tsp_bitmask_dp_3d_cost.sv
// ----------------------------------------------------------------------------
// tsp_bitmask_dp_3d_cost
// Closed-tour cost engine over up to MAX_CITIES cities in 3-D. Loads city
// beats, builds the directed edge costs, runs the subset DP and returns the
// cheapest tour from city 0 back to city 0.
//
//   Channel   Dir  Beat contents                         Notes
//   city_i    in   coord_x, coord_y, coord_z, last_city  last_city starts a run
//   result_o  out  tour_cost, too_many                   one beat per run
//
// City beats are taken one per cycle while loading. After the closing beat
// the block stops taking beats while the edge sweep and then the DP run; the
// DP is bounded by the single read port of the DP memory. A single city
// skips the sweep and the DP. Loading of the next set resumes as soon as
// the result sits in the output register, even while it is stalled. Reset
// clears the load count and control; memories are not cleared.
// ----------------------------------------------------------------------------
module tsp_bitmask_dp_3d_cost (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsp_city_if.sink     city_i,
  tsp_result_if.source result_o
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {
    T_LOAD,
    T_EDGE,
    T_DP,
    T_HOLD
  } state_e;

  state_e    state_q;
  city_cnt_t count_q;
  logic      ovf_q;
  logic      edge_start_q;
  logic      dp_start_q;
  logic      out_valid_q;

  city_cnt_t n_q;
  logic      run_ovf_q;
  tour_t     run_cost_q;
  tour_t     out_cost_q;
  logic      out_ovf_q;

  logic       accept, has_room, close_run, out_free;
  city_cnt_t  n_now;
  run_ctl_t   edge_ctl, dp_ctl;
  dp_stat_t   dp_stat;
  city_idx_t  city_raddr;
  coord_t     rd_x, rd_y, rd_z;
  logic       edge_we, edge_done;
  edge_addr_t edge_waddr, edge_raddr;
  edge_t      edge_wdata, edge_rdata;

  assign city_i.ready = (state_q == T_LOAD);
  assign accept       = city_i.valid && city_i.ready;
  assign has_room     = (count_q < city_cnt_t'(MAX_CITIES));
  assign close_run    = accept && city_i.last_city;
  assign n_now        = has_room ? (count_q + 1'b1) : count_q;
  assign out_free     = !out_valid_q || result_o.ready;

  assign edge_ctl.start = edge_start_q;
  assign edge_ctl.n     = n_q;
  assign dp_ctl.start   = dp_start_q;
  assign dp_ctl.n       = n_q;

  // City coordinate stores, written while loading.
  tsp_ram #(.WIDTH(COORD_BITS), .DEPTH(CITY_DEPTH)) u_city_x (
    .clk_i   (clk_i),
    .we_i    (accept && has_room),
    .waddr_i (count_q[CITY_W-1:0]),
    .wdata_i (city_i.coord_x[COORD_BITS-1:0]),
    .raddr_i (city_raddr),
    .rdata_o (rd_x)
  );

  tsp_ram #(.WIDTH(COORD_BITS), .DEPTH(CITY_DEPTH)) u_city_y (
    .clk_i   (clk_i),
    .we_i    (accept && has_room),
    .waddr_i (count_q[CITY_W-1:0]),
    .wdata_i (city_i.coord_y[COORD_BITS-1:0]),
    .raddr_i (city_raddr),
    .rdata_o (rd_y)
  );

  tsp_ram #(.WIDTH(COORD_BITS), .DEPTH(CITY_DEPTH)) u_city_z (
    .clk_i   (clk_i),
    .we_i    (accept && has_room),
    .waddr_i (count_q[CITY_W-1:0]),
    .wdata_i (city_i.coord_z[COORD_BITS-1:0]),
    .raddr_i (city_raddr),
    .rdata_o (rd_z)
  );

  // Directed edge costs.
  tsp_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  tsp_edge_build u_edge_build (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (edge_ctl),
    .city_raddr_o (city_raddr),
    .city_x_i     (rd_x),
    .city_y_i     (rd_y),
    .city_z_i     (rd_z),
    .edge_we_o    (edge_we),
    .edge_waddr_o (edge_waddr),
    .edge_wdata_o (edge_wdata),
    .done_o       (edge_done)
  );

  tsp_dp_core u_dp_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (dp_ctl),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .stat_o       (dp_stat)
  );

  // Load, run and hand-off control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_LOAD;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      edge_start_q <= 1'b0;
      dp_start_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      edge_start_q <= 1'b0;
      dp_start_q   <= 1'b0;
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (city_i.last_city) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              if (n_now == city_cnt_t'(1)) begin
                state_q <= T_HOLD;
              end else begin
                edge_start_q <= 1'b1;
                state_q      <= T_EDGE;
              end
            end
          end
        end
        T_EDGE: begin
          if (edge_done) begin
            dp_start_q <= 1'b1;
            state_q    <= T_DP;
          end
        end
        T_DP: begin
          if (dp_stat.done) begin
            state_q <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= T_LOAD;
          end
        end
        default: state_q <= T_LOAD;
      endcase
    end
  end

  // Run parameters and the output register.
  always_ff @(posedge clk_i) begin
    if (close_run) begin
      n_q        <= n_now;
      run_ovf_q  <= ovf_q || !has_room;
      run_cost_q <= '0;
    end
    if (state_q == T_DP && dp_stat.done) begin
      run_cost_q <= dp_stat.cost;
    end
    if (state_q == T_HOLD && out_free) begin
      out_cost_q <= run_cost_q;
      out_ovf_q  <= run_ovf_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.tour_cost = out_cost_q;
  assign result_o.too_many  = out_ovf_q;

endmodule

>>> sv/tsp_ram.sv
// ----------------------------------------------------------------------------
// tsp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tsp_edge_build.sv
// ----------------------------------------------------------------------------
// tsp_edge_build
// Sweeps all ordered city pairs and writes the directed edge cost
// |dx| + |dy| + max(0, z_to - z_from) into the edge memory.
// ----------------------------------------------------------------------------
module tsp_edge_build (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsp_pkg::run_ctl_t    ctl_i,
  output tsp_pkg::city_idx_t   city_raddr_o,
  input  tsp_pkg::coord_t      city_x_i,
  input  tsp_pkg::coord_t      city_y_i,
  input  tsp_pkg::coord_t      city_z_i,
  output logic                 edge_we_o,
  output tsp_pkg::edge_addr_t  edge_waddr_o,
  output tsp_pkg::edge_t       edge_wdata_o,
  output logic                 done_o
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_RD_A,
    E_SWEEP,
    E_DRAIN
  } state_e;

  state_e     state_q;
  city_idx_t  a_q, b_q;
  city_cnt_t  n_q;
  logic       p0_v_q, s1_v_q, s2_v_q;
  logic       done_q;

  coord_t     ax_q, ay_q, az_q;
  edge_addr_t p0_tag_q, s1_tag_q, s2_tag_q;
  diff_t      s1_dx_q, s1_dy_q, s1_dz_q;
  mag_t       s2_mx_q, s2_my_q, s2_mz_q;

  city_idx_t  last_idx;
  logic       pipe_busy;

  assign last_idx  = city_idx_t'(n_q - 1'b1);
  assign pipe_busy = p0_v_q | s1_v_q | s2_v_q;

  // The source city is read once per row, then each destination once a cycle.
  assign city_raddr_o = (state_q == E_RD_A) ? a_q : b_q;

  // Sequencer over rows (source) and columns (destination).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      n_q     <= '0;
      p0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      p0_v_q <= (state_q == E_SWEEP);
      s1_v_q <= p0_v_q;
      s2_v_q <= s1_v_q;
      case (state_q)
        E_IDLE: begin
          if (ctl_i.start) begin
            n_q     <= ctl_i.n;
            a_q     <= '0;
            state_q <= E_RD_A;
          end
        end
        E_RD_A: begin
          b_q     <= '0;
          state_q <= E_SWEEP;
        end
        E_SWEEP: begin
          if (b_q == last_idx) begin
            if (a_q == last_idx) begin
              state_q <= E_DRAIN;
            end else begin
              a_q     <= a_q + 1'b1;
              state_q <= E_RD_A;
            end
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        E_DRAIN: begin
          if (!pipe_busy) begin
            done_q  <= 1'b1;
            state_q <= E_IDLE;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  // Cost datapath: differences, then magnitudes, then the three-way sum.
  always_ff @(posedge clk_i) begin
    // The first sweep cycle sees the source city on the read port.
    if (state_q == E_SWEEP && b_q == '0) begin
      ax_q <= city_x_i;
      ay_q <= city_y_i;
      az_q <= city_z_i;
    end
    p0_tag_q <= {a_q, b_q};
    s1_tag_q <= p0_tag_q;
    s2_tag_q <= s1_tag_q;
    s1_dx_q  <= $signed({city_x_i[COORD_BITS-1], city_x_i})
              - $signed({ax_q[COORD_BITS-1], ax_q});
    s1_dy_q  <= $signed({city_y_i[COORD_BITS-1], city_y_i})
              - $signed({ay_q[COORD_BITS-1], ay_q});
    s1_dz_q  <= $signed({city_z_i[COORD_BITS-1], city_z_i})
              - $signed({az_q[COORD_BITS-1], az_q});
    s2_mx_q  <= s1_dx_q[COORD_BITS] ? mag_t'(-s1_dx_q) : mag_t'(s1_dx_q);
    s2_my_q  <= s1_dy_q[COORD_BITS] ? mag_t'(-s1_dy_q) : mag_t'(s1_dy_q);
    // Descending is free.
    s2_mz_q  <= s1_dz_q[COORD_BITS] ? '0 : mag_t'(s1_dz_q);
  end

  assign edge_we_o    = s2_v_q;
  assign edge_waddr_o = s2_tag_q;
  assign edge_wdata_o = edge_t'(s2_mx_q) + edge_t'(s2_my_q) + edge_t'(s2_mz_q);
  assign done_o       = done_q;

endmodule

>>> sv/tsp_dp_core.sv
// ----------------------------------------------------------------------------
// tsp_dp_core
// Held-Karp subset DP in pull form. For each subset and each end city in it,
// the best path cost is the minimum over the subset's other members of their
// path cost plus the closing edge; the table lives in one large RAM.
// ----------------------------------------------------------------------------
module tsp_dp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsp_pkg::run_ctl_t    ctl_i,
  output tsp_pkg::edge_addr_t  edge_raddr_o,
  input  tsp_pkg::edge_t       edge_rdata_i,
  output tsp_pkg::dp_stat_t    stat_o
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE,
    D_PICK,
    D_ISSUE,
    D_LAST,
    D_WRITE
  } state_e;

  state_e    state_q;
  city_cnt_t n_q;
  mask_t     full_q;
  mask_t     mask_q;
  city_idx_t j_q;
  city_idx_t k_q;
  logic      fin_q;
  logic      rv_q;
  logic      done_q;

  logic      rk0_q;
  tour_t     acc_q;
  tour_t     cost_q;

  city_idx_t jm1, km1, last_idx;
  mask_t     jbit, kbit, prev;
  logic      in_mask, k_valid, last_j, last_k;
  tour_t     cand;
  logic      dp_we;
  dp_addr_t  dp_waddr, dp_raddr;
  tour_t     dp_rdata;

  // Subset bookkeeping. Bit i of a mask stands for city i + 1.
  assign jm1      = j_q - 1'b1;
  assign km1      = k_q - 1'b1;
  assign last_idx = city_idx_t'(n_q - 1'b1);
  assign jbit     = mask_t'(1) << jm1;
  assign kbit     = mask_t'(1) << km1;
  assign in_mask  = |(mask_q & jbit);
  // The closing pass pulls city 0 from the full subset.
  assign prev     = fin_q ? full_q : (mask_q & ~jbit);
  // Start city 0 is the predecessor only of a single-city subset.
  assign k_valid  = (k_q == '0) ? (prev == '0) : |(prev & kbit);
  assign last_j   = (j_q == last_idx);
  assign last_k   = (k_q == last_idx);

  // Reads for predecessor k: edge k -> j and the path cost ending at k.
  assign edge_raddr_o = {k_q, j_q};
  assign dp_raddr     = {prev, km1};
  assign dp_we        = (state_q == D_WRITE) && !fin_q;
  assign dp_waddr     = {mask_q, jm1};

  assign cand = (rk0_q ? tour_t'(0) : dp_rdata) + tour_t'(edge_rdata_i);

  tsp_ram #(
    .WIDTH (TOUR_W),
    .DEPTH (DP_DEPTH)
  ) u_dp_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (acc_q),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

  // Sequencer: subsets in increasing order, end cities, then predecessors.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      n_q     <= '0;
      full_q  <= '0;
      mask_q  <= '0;
      j_q     <= '0;
      k_q     <= '0;
      fin_q   <= 1'b0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      rv_q   <= (state_q == D_ISSUE) && k_valid;
      case (state_q)
        D_IDLE: begin
          if (ctl_i.start) begin
            n_q     <= ctl_i.n;
            full_q  <= ~(mask_t'('1) << (ctl_i.n - 1'b1));
            mask_q  <= mask_t'(1);
            j_q     <= city_idx_t'(1);
            fin_q   <= 1'b0;
            state_q <= D_PICK;
          end
        end
        D_PICK: begin
          if (fin_q || in_mask) begin
            k_q     <= '0;
            state_q <= D_ISSUE;
          end else if (!last_j) begin
            j_q <= j_q + 1'b1;
          end else if (mask_q != full_q) begin
            mask_q <= mask_q + 1'b1;
            j_q    <= city_idx_t'(1);
          end else begin
            fin_q <= 1'b1;
            j_q   <= '0;
          end
        end
        D_ISSUE: begin
          if (last_k) begin
            state_q <= D_LAST;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        D_LAST: begin
          state_q <= D_WRITE;
        end
        D_WRITE: begin
          state_q <= D_PICK;
          if (fin_q) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (!last_j) begin
            j_q <= j_q + 1'b1;
          end else if (mask_q != full_q) begin
            mask_q <= mask_q + 1'b1;
            j_q    <= city_idx_t'(1);
          end else begin
            fin_q <= 1'b1;
            j_q   <= '0;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  // Running minimum over the predecessors of the current entry.
  always_ff @(posedge clk_i) begin
    rk0_q <= (k_q == '0);
    if (state_q == D_PICK) begin
      acc_q <= '1;
    end else if (rv_q && (cand < acc_q)) begin
      acc_q <= cand;
    end
    if (state_q == D_WRITE && fin_q) begin
      cost_q <= acc_q;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.cost = cost_q;

endmodule

>>> sv/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tour cost engine, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_last_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input tsp_pkg::tour_t out_cost_i,
  input logic           out_too_many_i
);

  // A stalled result beat stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_cost_i) && $stable(out_too_many_i))
    else $error("result payload changed while stalled");

  // The closing city beat starts a run, which takes no further beats.
  a_run_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("city beat taken right after the closing beat");

  // A new result only appears at the end of a run.
  a_result_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while loading");

endmodule

bind tsp_bitmask_dp_3d_cost tsp_checker u_tsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (city_i.valid),
  .in_ready_i     (city_i.ready),
  .in_last_i      (city_i.last_city),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_cost_i     (result_o.tour_cost),
  .out_too_many_i (result_o.too_many)
);
